@@ src/rnfk_pkg.sv @@
// ----------------------------------------------------------------------------
// rnfk_pkg
// Shared types, codes and defaults for the random nth-free key allocator.
// ----------------------------------------------------------------------------
package rnfk_pkg;

    localparam int KEY_BITS_DEF  = 12;
    localparam int WORD_BITS_DEF = 64;

    localparam int KEY_W    = 32;
    localparam int RND_W    = 24;
    localparam int DOMAIN_W = 12;
    localparam int CFG_IDX_W = 1;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOSPACE  = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_MISMATCH = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RO_DOMAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RW_DOMAIN = 1'd1;

    localparam logic [DOMAIN_W-1:0] RO_DOMAIN_RST = 12'd2;
    localparam logic [DOMAIN_W-1:0] RW_DOMAIN_RST = 12'd3;

endpackage

@@ src/rnfk_ifs.sv @@
// ----------------------------------------------------------------------------
// rnfk interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rnfk_req_if;
    import rnfk_pkg::*;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [RND_W-1:0] random_value;
    logic [KEY_W-1:0] ro_key_in;
    logic [KEY_W-1:0] rw_key_in;
    modport source (output valid, opcode, random_value, ro_key_in, rw_key_in, input ready);
    modport sink   (input valid, opcode, random_value, ro_key_in, rw_key_in, output ready);
endinterface

interface rnfk_rsp_if;
    import rnfk_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] ro_key_out;
    logic [KEY_W-1:0] rw_key_out;
    status_t          status;
    modport source (output valid, ro_key_out, rw_key_out, status, input ready);
    modport sink   (input valid, ro_key_out, rw_key_out, status, output ready);
endinterface

interface rnfk_cfg_if;
    import rnfk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DOMAIN_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/random_nth_free_key_allocator.sv @@
// ----------------------------------------------------------------------------
// random_nth_free_key_allocator
// Bitmap key allocator: picks a random free key by rank, frees key pairs.
// ----------------------------------------------------------------------------
// After reset the block clears its word memory, one word per cycle
// (2^KEY_BITS / WORD_BITS words, 64 at the defaults), and takes no request
// meanwhile; config writes are taken at any time. One request is in work at
// a time. An allocate runs a bit-serial remainder, then reads and checks
// bitmap words one by one, walks the bits of the chosen word and writes it
// back; its pace is set by the single memory port and the serial units.
// A free reads the key's word, checks the bit and clears it if set; a request
// rejected on entry (no space, pair mismatch) goes straight to output. The result
// sits in an output register so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module random_nth_free_key_allocator #(
    parameter int KEY_BITS  = rnfk_pkg::KEY_BITS_DEF,
    parameter int WORD_BITS = rnfk_pkg::WORD_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    rnfk_req_if.sink   req,
    rnfk_rsp_if.source rsp,
    rnfk_cfg_if.sink   cfg
);
    import rnfk_pkg::*;

    localparam int LOG_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (1 << KEY_BITS) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = LOG_W + 1;
    localparam int OW        = (KEY_BITS > CNT_W) ? KEY_BITS : CNT_W;
    localparam int MEM_W     = WORD_BITS + CNT_W;
    localparam int DIV_CW    = $clog2(RND_W);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_BIT      = 4'd5;
    localparam logic [3:0] S_WRITE    = 4'd6;
    localparam logic [3:0] S_FREE_RD  = 4'd7;
    localparam logic [3:0] S_FREE_CHK = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    localparam logic [KEY_BITS-1:0] KEY_FULL = '1;

    logic [3:0]            state_reg, state_next;
    logic [WIDX_W-1:0]     w_reg, w_next;
    logic [LOG_W-1:0]      b_reg, b_next;
    logic [KEY_BITS-1:0]   ord_reg, ord_next;
    logic [KEY_BITS-1:0]   rem_reg, rem_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [DIV_CW-1:0]     div_cnt_reg, div_cnt_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   total_reg, total_next;
    status_t               res_status_reg, res_status_next;
    logic                  res_key_reg, res_key_next;

    logic [DOMAIN_W-1:0]   ro_domain_reg, rw_domain_reg;
    logic                  out_valid_reg;
    logic [KEY_W-1:0]      out_ro_reg, out_rw_reg;
    status_t               out_status_reg;

    logic                  mem_we, mem_re;
    logic [WIDX_W-1:0]     mem_waddr, mem_raddr;
    logic [MEM_W-1:0]      mem_wdata, mem_rdata;
    logic [WORD_BITS-1:0]  rd_word;
    logic [CNT_W-1:0]      rd_cnt, rd_free;
    logic [KEY_BITS:0]     div_trial;
    logic [WIDX_W-1:0]     req_widx, key_widx;
    logic [KEY_BITS-1:0]   found_key;
    logic                  out_load;

    assign rd_word  = mem_rdata[WORD_BITS-1:0];
    assign rd_cnt   = mem_rdata[MEM_W-1:WORD_BITS];
    assign rd_free  = (rd_cnt >= CNT_W'(WORD_BITS)) ? '0 : CNT_W'(WORD_BITS) - rd_cnt;
    assign div_trial = {ord_reg, rnd_reg[RND_W-1]};
    assign req_widx = WIDX_W'(req.ro_key_in[KEY_BITS-1:0] >> LOG_W);
    assign key_widx = WIDX_W'(key_reg >> LOG_W);
    assign found_key = (KEY_BITS'(w_reg) << LOG_W) | KEY_BITS'(b_reg);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    rnfk_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        b_next          = b_reg;
        ord_next        = ord_reg;
        rem_next        = rem_reg;
        rnd_next        = rnd_reg;
        div_cnt_next    = div_cnt_reg;
        word_next       = word_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        mem_we          = 1'b0;
        mem_waddr       = w_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = w_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                w_next = w_reg + 1'b1;
                if (w_reg == WIDX_W'(NUM_WORDS - 1))
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_key_next = 1'b0;
                    if (req.opcode == OP_ALLOC)
                    begin
                        if (total_reg == KEY_FULL)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            rem_next     = KEY_FULL - total_reg;
                            rnd_next     = req.random_value;
                            ord_next     = '0;
                            div_cnt_next = DIV_CW'(RND_W - 1);
                            state_next   = S_DIV;
                        end
                    end
                    else
                    begin
                        key_next = req.ro_key_in[KEY_BITS-1:0];
                        if (req.ro_key_in[KEY_BITS-1:0] != req.rw_key_in[KEY_BITS-1:0])
                        begin
                            res_status_next = ST_MISMATCH;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                    w_next = '0;
                    if (req.opcode == OP_FREE)
                    begin
                        w_next = req_widx;
                    end
                end
            end
            S_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                if (div_trial >= {1'b0, rem_reg})
                begin
                    ord_next = KEY_BITS'(div_trial - {1'b0, rem_reg});
                end
                else
                begin
                    ord_next = KEY_BITS'(div_trial);
                end
                rnd_next     = rnd_reg << 1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    ord_next   = ord_next + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (OW'(ord_reg) >= OW'(rd_free))
                begin
                    ord_next = ord_reg - KEY_BITS'(rd_free);
                    w_next   = w_reg + 1'b1;
                    state_next = S_SCAN_RD;
                    if (w_reg == WIDX_W'(NUM_WORDS - 1))
                    begin
                        res_status_next = ST_NOSPACE;
                        state_next      = S_OUT;
                    end
                end
                else
                begin
                    word_next  = rd_word;
                    cnt_next   = rd_cnt;
                    b_next     = '0;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                b_next = b_reg + 1'b1;
                if (!word_reg[b_reg] && ord_reg == '0)
                begin
                    key_next   = found_key;
                    state_next = S_WRITE;
                end
                else
                begin
                    if (!word_reg[b_reg])
                    begin
                        ord_next = ord_reg - 1'b1;
                    end
                    if (b_reg == LOG_W'(WORD_BITS - 1))
                    begin
                        res_status_next = ST_NOSPACE;
                        state_next      = S_OUT;
                    end
                end
            end
            S_WRITE:
            begin
                mem_we          = 1'b1;
                mem_wdata       = {cnt_reg + 1'b1,
                                   word_reg | (WORD_BITS'(1) << key_reg[LOG_W-1:0])};
                total_next      = total_reg + 1'b1;
                res_status_next = ST_OK;
                res_key_next    = 1'b1;
                state_next      = S_OUT;
            end
            S_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = key_widx;
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (!rd_word[key_reg[LOG_W-1:0]])
                begin
                    res_status_next = ST_NOTFOUND;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = key_widx;
                    mem_wdata = {(rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt,
                                 rd_word & ~(WORD_BITS'(1) << key_reg[LOG_W-1:0])};
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - 1'b1;
                    end
                    res_status_next = ST_OK;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            w_reg         <= '0;
            total_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            ro_domain_reg <= RO_DOMAIN_RST;
            rw_domain_reg <= RW_DOMAIN_RST;
        end
        else
        begin
            state_reg   <= state_next;
            w_reg       <= w_next;
            total_reg   <= total_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg.valid && cfg.index == REG_RO_DOMAIN)
            begin
                ro_domain_reg <= cfg.data;
            end
            if (cfg.valid && cfg.index == REG_RW_DOMAIN)
            begin
                rw_domain_reg <= cfg.data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg          <= b_next;
        ord_reg        <= ord_next;
        rem_reg        <= rem_next;
        rnd_reg        <= rnd_next;
        word_reg       <= word_next;
        cnt_reg        <= cnt_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            if (res_key_reg)
            begin
                out_ro_reg <= KEY_W'(key_reg) | (KEY_W'(ro_domain_reg) << KEY_BITS);
                out_rw_reg <= KEY_W'(key_reg) | (KEY_W'(rw_domain_reg) << KEY_BITS);
            end
            else
            begin
                out_ro_reg <= '0;
                out_rw_reg <= '0;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ro_key_out = out_ro_reg;
    assign rsp.rw_key_out = out_rw_reg;
    assign rsp.status     = out_status_reg;

    // a taken request keeps the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request channel ready right after a transaction");

    // a failed result never carries a key
    a_fail_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.ro_key_out == '0 && rsp.rw_key_out == '0))
        else $error("key on failed result");

    // the allocated count only moves on an allocate write or a free
    a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE && state_reg != S_FREE_CHK) |=> $stable(total_reg))
        else $error("allocated count changed outside update states");

endmodule

@@ src/rnfk_ram.sv @@
// ----------------------------------------------------------------------------
// rnfk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rnfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
